@@ hw/rtl/sbf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbf_pkg
// shared types and constants of the scheduled backlight fader
// ----------------------------------------------------------------------------
package sbf_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TAP    = 2'd1,
        KIND_MANUAL = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DAY_START   = 3'd0,
        CFG_DAY_END     = 3'd1,
        CFG_DAY_LEVEL   = 3'd2,
        CFG_NIGHT_LEVEL = 3'd3,
        CFG_PEEK_LEVEL  = 3'd4,
        CFG_FADE_TIME   = 3'd5,
        CFG_PEEK_TIME   = 3'd6
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_FADE,
        S_DIV,
        S_MUL,
        S_STEP,
        S_DONE
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // divider geometry: 48-bit dividend, 16-bit divisor, quotient saturated at 20 bits
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_Q_W   = 20;

    // touch strip geometry
    localparam logic [9:0] STRIP_TOP    = 10'd40;
    localparam logic [9:0] STRIP_BOTTOM = 10'd440;
    localparam logic       STRIP_EMPTY  = (STRIP_BOTTOM <= STRIP_TOP);
    localparam logic [9:0] STRIP_SPAN   = STRIP_EMPTY ? 10'd0 : (STRIP_BOTTOM - STRIP_TOP);

    // touch scaling by reciprocal: ceil(2^30 / span), exact for any strip
    // of up to 1023 pixels since 1023*255 times the rounding error stays below 2^30
    localparam logic [9:0]  STRIP_DIV = STRIP_EMPTY ? 10'd1 : STRIP_SPAN;
    localparam int          MAN_SHIFT = 30;
    localparam logic [63:0] MAN_ONE   = 64'd1 << MAN_SHIFT;
    localparam logic [30:0] MAN_RECIP = 31'((MAN_ONE + 64'(STRIP_DIV) - 64'd1) / 64'(STRIP_DIV));

    // easing factors in Q0.16: 0.12 of the gap, 0.15 of the rate limit
    localparam logic [12:0] EASE_Q16  = 13'd7864;
    localparam logic [13:0] FLOOR_Q16 = 14'd9830;

    // full duty 255; shifted up by 8 bits it is full scale in Q8.8
    localparam logic [7:0] FULL_DUTY = 8'd255;

endpackage
`default_nettype wire

@@ hw/rtl/sbf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbf_div
// restoring divider, one quotient bit per cycle, quotient saturates
// ----------------------------------------------------------------------------
module sbf_div
    import sbf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic      [DIV_Q_W-1:0]   o_quot,
    output t_div_stat                 o_stat
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [DIV_DEN_W-1:0] r_den, n_den;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_Q_W-1:0]   r_q, n_q;
    logic                 r_ovf, n_ovf;

    logic [DIV_DEN_W:0]   w_rem_sh;
    logic [DIV_DEN_W:0]   w_rem_sub;
    logic                 w_fits;

    // one compare and subtract per cycle
    assign w_rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_fits    = (w_rem_sh >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_NUM_W - 1);
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_q    = '0;
            n_ovf  = 1'b0;
        end else if (r_busy) begin
            n_num = {r_num[DIV_NUM_W-2:0], 1'b0};
            n_rem = w_fits ? w_rem_sub[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
            n_q   = {r_q[DIV_Q_W-2:0], w_fits};
            // any bit pushed out of the top saturates the result
            n_ovf = r_ovf | r_q[DIV_Q_W-1];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_ovf <= n_ovf;
    end

    assign o_quot      = r_ovf ? {DIV_Q_W{1'b1}} : r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
`default_nettype wire

@@ hw/rtl/scheduled_backlight_fader.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scheduled_backlight_fader
// backlight duty controller: day/night schedule, night peek, manual touch
// and an eased, rate-limited fade in unsigned Q8.8
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ------------------------------
//  in       sink       i_in_valid / o_in_stall   kind, now_ms, clock_valid,
//                                                minute_of_day, touch_y
//  out      source     o_out_valid / i_out_stall duty, duty_written, daytime,
//                                                manual_on, peek_on,
//                                                refresh_request
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  a fading tick runs eval, fade, the 48-step restoring divider (one quotient
//  bit a cycle), mul, step and done; a manual touch eval, mul, done; a tick
//  that does not move the level eval, fade, done; a tap or an unknown kind eval,
//  done; the next transaction is taken the cycle after the result loads, even
//  while it still waits; each stalled cycle of a waiting result holds the
//  sequencer in done; reset (synchronous, active low) loads defaults
//
module scheduled_backlight_fader
    import sbf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_clock_valid,
    input  wire logic [10:0] i_minute_of_day,
    input  wire logic [9:0]  i_touch_y,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_duty,
    output logic             o_duty_written,
    output logic             o_daytime,
    output logic             o_manual_on,
    output logic             o_peek_on,
    output logic             o_refresh_request,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------

    t_state r_state, n_state;

    // configuration
    logic [10:0] r_day_start, r_day_end;
    logic [7:0]  r_day_level, r_night_level, r_peek_level;
    logic [15:0] r_fade_time;
    logic [31:0] r_peek_time;

    // schedule and fade state
    logic [15:0] r_level, n_level;         // present level, Q8.8
    logic [7:0]  r_goal, n_goal;           // goal duty
    logic [31:0] r_last_fade, n_last_fade;
    logic        r_clk_set, n_clk_set;     // fade clock loaded once
    logic        r_prev_day, n_prev_day;
    logic        r_known_day, n_known_day;
    logic        r_peek, n_peek;
    logic [31:0] r_peek_end, n_peek_end;
    logic        r_override, n_override;

    // latched transaction
    logic [1:0]  r_kind;
    logic [31:0] r_now;
    logic        r_clock_valid;
    logic [10:0] r_minute;
    logic [9:0]  r_touch_y;

    // working values
    logic [15:0] r_gap, n_gap;             // |goal - level|, Q8.8
    logic        r_up, n_up;               // fade direction
    logic [19:0] r_max, n_max;             // rate limited step, saturated
    logic [12:0] r_ease, n_ease;           // 0.12 of the gap
    logic [17:0] r_lo, n_lo;               // 0.15 of the rate limit
    logic [17:0] r_man_num, n_man_num;     // 255 times the distance to the strip bottom
    logic        r_written, n_written;
    logic        r_refresh, n_refresh;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_duty;
    logic        r_duty_written, r_daytime, r_manual_on, r_peek_on, r_refresh_request;

    // ------------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------------

    logic        w_in_acc;
    logic        w_out_free;
    logic        w_day;
    logic        w_day_change;
    logic        w_peek_kept;
    logic [31:0] w_dt;
    logic [15:0] w_goal_q;
    logic [9:0]  w_touch_clamp;
    logic [9:0]  w_strip_diff;
    logic [17:0] w_man_num;
    logic [48:0] w_man_prod;
    logic [48-MAN_SHIFT:0] w_man_q;
    logic [47:0] w_fade_num;
    logic [15:0] w_fade_den;
    logic        w_fade_go;
    logic        w_div_start;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic [DIV_Q_W-1:0]   w_div_quot;
    t_div_stat   w_div_stat;
    logic [7:0]  w_man_duty;
    logic [28:0] w_ease_prod;
    logic [33:0] w_lo_prod;
    logic [19:0] w_step_a, w_step_b, w_step;
    logic        w_snap;
    logic [16:0] w_duty_sum;
    logic [7:0]  w_duty;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // schedule: keep the last known state while the clock is not valid
    assign w_day = r_clock_valid ? ((r_minute >= r_day_start) && (r_minute < r_day_end))
                                 : r_known_day;
    assign w_day_change = (w_day != r_prev_day);
    assign w_peek_kept  = w_day_change ? 1'b0 : r_peek;

    assign w_goal_q = {r_goal, 8'h00};
    assign w_dt     = r_now - r_last_fade;

    // rate limit numerator 255*256*dt, built from shifts
    assign w_fade_num = {w_dt, 16'h0000} - {8'h00, w_dt, 8'h00};
    assign w_fade_den = (r_fade_time == 16'd0) ? 16'd1 : r_fade_time;
    assign w_fade_go  = r_clk_set && (w_dt != 32'd0) && (r_level != w_goal_q);

    // manual touch: clamp into the strip, then scale over its span
    always_comb begin
        w_touch_clamp = r_touch_y;
        if (r_touch_y < STRIP_TOP) begin
            w_touch_clamp = STRIP_TOP;
        end
        if (r_touch_y > STRIP_BOTTOM) begin
            w_touch_clamp = STRIP_BOTTOM;
        end
    end
    assign w_strip_diff = STRIP_BOTTOM - w_touch_clamp;
    assign w_man_num    = 18'(w_strip_diff) * 18'(FULL_DUTY);

    // division by the span as a reciprocal multiply on the registered numerator
    assign w_man_prod = 49'(r_man_num) * 49'(MAN_RECIP);
    assign w_man_q    = w_man_prod[48:MAN_SHIFT];
    assign w_man_duty = STRIP_EMPTY ? 8'd0
                      : ((|w_man_q[48-MAN_SHIFT:8]) ? FULL_DUTY : w_man_q[7:0]);

    // the divider serves the fade rate
    assign w_div_start = (r_state == S_FADE) && w_fade_go;
    assign w_div_num   = w_fade_num;
    assign w_div_den   = w_fade_den;

    sbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quot  (w_div_quot),
        .o_stat  (w_div_stat)
    );

    // easing products, each registered
    assign w_ease_prod = 29'(r_gap) * 29'(EASE_Q16);
    assign w_lo_prod   = 34'(r_max) * 34'(FLOOR_Q16);

    // step: raise to the floor, limit to the rate, at least one lsb
    assign w_step_a = (20'(r_ease) < 20'(r_lo)) ? 20'(r_lo) : 20'(r_ease);
    assign w_step_b = (w_step_a > r_max) ? r_max : w_step_a;
    assign w_step   = (w_step_b == 20'd0) ? 20'd1 : w_step_b;
    assign w_snap   = (20'(r_gap) <= w_step);

    // rounded duty, saturated
    assign w_duty_sum = {1'b0, r_level} + 17'd128;
    assign w_duty     = w_duty_sum[16] ? 8'hFF : w_duty_sum[15:8];

    // ------------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------------

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_kind == KIND_TICK) begin
                    n_state = S_FADE;
                end else if (r_kind == KIND_MANUAL) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FADE: begin
                n_state = w_fade_go ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = (r_kind == KIND_MANUAL) ? S_DONE : S_STEP;
            end
            S_STEP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer: datapath updates
    // ------------------------------------------------------------------------

    always_comb begin
        n_level     = r_level;
        n_goal      = r_goal;
        n_last_fade = r_last_fade;
        n_clk_set   = r_clk_set;
        n_prev_day  = r_prev_day;
        n_known_day = r_known_day;
        n_peek      = r_peek;
        n_peek_end  = r_peek_end;
        n_override  = r_override;
        n_gap       = r_gap;
        n_up        = r_up;
        n_max       = r_max;
        n_ease      = r_ease;
        n_lo        = r_lo;
        n_man_num   = r_man_num;
        n_written   = r_written;
        n_refresh   = r_refresh;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_EVAL: begin
                n_written = 1'b0;
                n_refresh = 1'b0;
                case (r_kind)
                    KIND_TICK: begin
                        n_known_day = w_day;
                        n_prev_day  = w_day;
                        if (w_day_change) begin
                            n_goal     = w_day ? r_day_level : r_night_level;
                            n_peek     = 1'b0;
                            n_override = 1'b0;
                        end
                        // an expired peek falls back to the night duty
                        if (w_peek_kept && (r_now >= r_peek_end)) begin
                            n_goal = r_night_level;
                            n_peek = 1'b0;
                        end
                    end
                    KIND_TAP: begin
                        n_known_day = w_day;
                        if (w_day) begin
                            n_refresh = 1'b1;
                        end else if (r_peek || (r_goal != 8'd0)) begin
                            n_goal = r_night_level;
                            n_peek = 1'b0;
                        end else begin
                            n_goal     = r_peek_level;
                            n_peek     = 1'b1;
                            n_peek_end = r_now + r_peek_time;
                            n_refresh  = 1'b1;
                        end
                    end
                    KIND_MANUAL: begin
                        n_override = 1'b1;
                        n_peek     = 1'b0;
                        n_written  = 1'b1;
                        n_man_num  = w_man_num;
                    end
                    default: begin
                    end
                endcase
            end
            S_FADE: begin
                // first tick only loads the fade clock
                if (!r_clk_set) begin
                    n_last_fade = r_now;
                    n_clk_set   = 1'b1;
                end else if (w_dt != 32'd0) begin
                    n_last_fade = r_now;
                end
                n_up  = (w_goal_q > r_level);
                n_gap = (w_goal_q > r_level) ? (w_goal_q - r_level) : (r_level - w_goal_q);
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_max = w_div_quot;
                end
            end
            S_MUL: begin
                if (r_kind == KIND_MANUAL) begin
                    n_goal  = w_man_duty;
                    n_level = {w_man_duty, 8'h00};
                end else begin
                    n_ease = w_ease_prod[28:16];
                    n_lo   = w_lo_prod[33:16];
                end
            end
            S_STEP: begin
                n_written = 1'b1;
                if (w_snap) begin
                    n_level = w_goal_q;
                end else if (r_up) begin
                    n_level = r_level + w_step[15:0];
                end else begin
                    n_level = r_level - w_step[15:0];
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers with reset
    // ------------------------------------------------------------------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_day_start   <= 11'd420;
            r_day_end     <= 11'd1320;
            r_day_level   <= 8'd200;
            r_night_level <= 8'd0;
            r_peek_level  <= 8'd128;
            r_fade_time   <= 16'd1600;
            r_peek_time   <= 32'd30000;
            r_level       <= 16'd0;
            r_goal        <= 8'd200;
            r_last_fade   <= 32'd0;
            r_clk_set     <= 1'b0;
            r_prev_day    <= 1'b1;
            r_known_day   <= 1'b1;
            r_peek        <= 1'b0;
            r_peek_end    <= 32'd0;
            r_override    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_goal      <= n_goal;
            r_last_fade <= n_last_fade;
            r_clk_set   <= n_clk_set;
            r_prev_day  <= n_prev_day;
            r_known_day <= n_known_day;
            r_peek      <= n_peek;
            r_peek_end  <= n_peek_end;
            r_override  <= n_override;
            r_out_valid <= n_out_valid;
            // register writes, always ready; the sender keeps them to idle time
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DAY_START:   r_day_start   <= i_cfg_data[10:0];
                    CFG_DAY_END:     r_day_end     <= i_cfg_data[10:0];
                    CFG_DAY_LEVEL:   r_day_level   <= i_cfg_data[7:0];
                    CFG_NIGHT_LEVEL: r_night_level <= i_cfg_data[7:0];
                    CFG_PEEK_LEVEL:  r_peek_level  <= i_cfg_data[7:0];
                    CFG_FADE_TIME:   r_fade_time   <= i_cfg_data[15:0];
                    CFG_PEEK_TIME:   r_peek_time   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind        <= i_kind;
            r_now         <= i_now_ms;
            r_clock_valid <= i_clock_valid;
            r_minute      <= i_minute_of_day;
            r_touch_y     <= i_touch_y;
        end
        r_gap     <= n_gap;
        r_up      <= n_up;
        r_max     <= n_max;
        r_ease    <= n_ease;
        r_lo      <= n_lo;
        r_man_num <= n_man_num;
        r_written <= n_written;
        r_refresh <= n_refresh;
        if ((r_state == S_DONE) && w_out_free) begin
            r_duty            <= w_duty;
            r_duty_written    <= r_written;
            r_daytime         <= r_known_day;
            r_manual_on       <= r_override;
            r_peek_on         <= r_peek;
            r_refresh_request <= r_refresh;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_duty            = r_duty;
    assign o_duty_written    = r_duty_written;
    assign o_daytime         = r_daytime;
    assign o_manual_on       = r_manual_on;
    assign o_peek_on         = r_peek_on;
    assign o_refresh_request = r_refresh_request;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the level never passes full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= 16'hFF00)
        else $error("level above full scale");

    // an accepted transaction leaves idle at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted transaction not started");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider done outside wait state");

    // divider is never restarted while it runs
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    // a result appears only from the completion state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside completion state");

endmodule
`default_nettype wire

@@ dv/scheduled_backlight_fader_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_backlight_fader_chk
// watches the item, result and register channels of the backlight fader,
// keeps its own copy of schedule, peek, override and fade state, and
// compares every result against the predicted status
// ----------------------------------------------------------------------------
module scheduled_backlight_fader_chk
    import sbf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_clock_valid,
    input  wire logic [10:0] i_minute_of_day,
    input  wire logic [9:0]  i_touch_y,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  i_duty,
    input  wire logic        i_duty_written,
    input  wire logic        i_daytime,
    input  wire logic        i_manual_on,
    input  wire logic        i_peek_on,
    input  wire logic        i_refresh_request,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_mismatches,
    output int               o_outstanding,
    output int               o_results
);

    localparam logic [63:0] FULL_SCALE_Q8 = 64'd65280;
    localparam logic [63:0] EASE_FRAC     = 64'd7864;
    localparam logic [63:0] FLOOR_FRAC    = 64'd9830;

    typedef struct packed {
        logic [7:0] duty;
        logic       written;
        logic       daytime;
        logic       manual_on;
        logic       peek_on;
        logic       refresh;
    } t_status;

    // register copy
    logic [10:0] day_start_min, day_end_min;
    logic [7:0]  day_lvl, night_lvl, peek_lvl;
    logic [15:0] fade_ms;
    logic [31:0] peek_ms;

    // predicted block state
    logic [15:0] level_now;
    logic [7:0]  goal;
    logic [31:0] last_fade;
    logic        fade_clock_set;
    logic        prev_day, known_day, peek_on, override_on;
    logic [31:0] peek_end;

    t_status pending_status_q[$];
    t_status got, want;
    int      mismatch_count = 0;
    int      checked_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_results    = checked_count;

    task automatic report_mismatch(input string msg);
        $display("[chk] mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int got_v, input int want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      checked_count, name, got_v, want_v));
    endtask

    // one eased step of the fade, returns 1 when the level was rewritten
    function automatic logic fade_toward_goal(input logic [31:0] now);
        logic [31:0] dt;
        logic [15:0] goal_q, gap;
        logic [63:0] dt_w, gap_w, fade_div, rate_max, ease, lo;
        if (!fade_clock_set) begin
            last_fade      = now;
            fade_clock_set = 1'b1;
        end
        dt = now - last_fade;
        if (dt == 32'd0)
            return 1'b0;
        last_fade = now;
        goal_q    = {goal, 8'h00};
        if (level_now == goal_q)
            return 1'b0;
        dt_w     = dt;
        fade_div = (fade_ms == 16'd0) ? 64'd1 : {48'd0, fade_ms};
        rate_max = (FULL_SCALE_Q8 * dt_w) / fade_div;
        gap      = (goal_q > level_now) ? goal_q - level_now : level_now - goal_q;
        gap_w    = gap;
        ease     = (gap_w * EASE_FRAC) >> 16;
        lo       = (rate_max * FLOOR_FRAC) >> 16;
        if (ease < lo)
            ease = lo;
        if (ease > rate_max)
            ease = rate_max;
        if (ease < 64'd1)
            ease = 64'd1;
        if (gap_w <= ease)
            level_now = goal_q;
        else if (goal_q > level_now)
            level_now = level_now + ease[15:0];
        else
            level_now = level_now - ease[15:0];
        return 1'b1;
    endfunction

    function automatic t_status predict_backlight(input logic [1:0]  kind,
                                                  input logic [31:0] now,
                                                  input logic        cv,
                                                  input logic [10:0] minute,
                                                  input logic [9:0]  y);
        t_status     r;
        int          ty, v;
        logic [16:0] rounded;
        r = '0;
        case (kind)
            KIND_TICK: begin
                if (cv)
                    known_day = (minute >= day_start_min) && (minute < day_end_min);
                if (known_day != prev_day) begin
                    goal        = known_day ? day_lvl : night_lvl;
                    peek_on     = 1'b0;
                    override_on = 1'b0;
                end
                prev_day = known_day;
                // plain compare, a wrapped end time expires at once
                if (peek_on && now >= peek_end) begin
                    goal    = night_lvl;
                    peek_on = 1'b0;
                end
                r.written = fade_toward_goal(now);
            end
            KIND_TAP: begin
                if (cv)
                    known_day = (minute >= day_start_min) && (minute < day_end_min);
                if (known_day) begin
                    r.refresh = 1'b1;
                end else if (peek_on || goal != 8'd0) begin
                    goal    = night_lvl;
                    peek_on = 1'b0;
                end else begin
                    goal      = peek_lvl;
                    peek_on   = 1'b1;
                    peek_end  = now + peek_ms;
                    r.refresh = 1'b1;
                end
            end
            KIND_MANUAL: begin
                ty = y;
                if (ty < int'(STRIP_TOP))
                    ty = int'(STRIP_TOP);
                if (ty > int'(STRIP_BOTTOM))
                    ty = int'(STRIP_BOTTOM);
                v = 0;
                if (int'(STRIP_BOTTOM) > int'(STRIP_TOP))
                    v = (255 * (int'(STRIP_BOTTOM) - ty)) / (int'(STRIP_BOTTOM) - int'(STRIP_TOP));
                if (v > 255)
                    v = 255;
                goal        = v[7:0];
                level_now   = {v[7:0], 8'h00};
                override_on = 1'b1;
                peek_on     = 1'b0;
                r.written   = 1'b1;
            end
            default: ;
        endcase
        rounded     = {1'b0, level_now} + 17'd128;
        r.duty      = rounded[16] ? 8'hFF : rounded[15:8];
        r.daytime   = known_day;
        r.manual_on = override_on;
        r.peek_on   = peek_on;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            day_start_min  = 11'd420;
            day_end_min    = 11'd1320;
            day_lvl        = 8'd200;
            night_lvl      = 8'd0;
            peek_lvl       = 8'd128;
            fade_ms        = 16'd1600;
            peek_ms        = 32'd30000;
            level_now      = 16'd0;
            goal           = 8'd200;
            last_fade      = 32'd0;
            fade_clock_set = 1'b0;
            prev_day       = 1'b1;
            known_day      = 1'b1;
            peek_on        = 1'b0;
            peek_end       = 32'd0;
            override_on    = 1'b0;
            pending_status_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_duty, i_duty_written, i_daytime, i_manual_on, i_peek_on,
                        i_refresh_request};
                if (pending_status_q.size() == 0) begin
                    report_mismatch("result with no transaction waiting for it");
                end else begin
                    want = pending_status_q.pop_front();
                    compare_field("duty", got.duty, want.duty);
                    compare_field("duty_written", got.written, want.written);
                    compare_field("daytime", got.daytime, want.daytime);
                    compare_field("manual_on", got.manual_on, want.manual_on);
                    compare_field("peek_on", got.peek_on, want.peek_on);
                    compare_field("refresh_request", got.refresh, want.refresh);
                end
                checked_count++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DAY_START:   day_start_min = i_cfg_data[10:0];
                    CFG_DAY_END:     day_end_min   = i_cfg_data[10:0];
                    CFG_DAY_LEVEL:   day_lvl       = i_cfg_data[7:0];
                    CFG_NIGHT_LEVEL: night_lvl     = i_cfg_data[7:0];
                    CFG_PEEK_LEVEL:  peek_lvl      = i_cfg_data[7:0];
                    CFG_FADE_TIME:   fade_ms       = i_cfg_data[15:0];
                    CFG_PEEK_TIME:   peek_ms       = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                pending_status_q.push_back(predict_backlight(i_kind, i_now_ms, i_clock_valid,
                                                             i_minute_of_day, i_touch_y));
        end
        o_outstanding <= pending_status_q.size();
    end

endmodule

@@ dv/scheduled_backlight_fader_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_backlight_fader_tb
// drives ticks, taps and touches into the backlight fader across several
// register settings and handshake pressure levels; a side checker predicts
// each status transaction and this top only builds traffic and the verdict
// ----------------------------------------------------------------------------
module scheduled_backlight_fader_tb;
    import sbf_pkg::*;

    // kind with no meaning to the block, must come back as plain status
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         ITEMS_PER_PHASE = 138;
    localparam int         END_SETTLE = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    // item channel
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  in_kind = KIND_TICK;
    logic [31:0] in_now_ms = 32'd0;
    logic        in_clock_valid = 1'b0;
    logic [10:0] in_minute = 11'd0;
    logic [9:0]  in_touch_y = 10'd0;

    // result channel
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_duty;
    logic        out_written, out_daytime, out_manual_on, out_peek_on, out_refresh;

    // register channel
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_DAY_START;
    logic [31:0] cfg_data = 32'd0;

    int mismatches, outstanding, results;

    // traffic shaping and bookkeeping
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic [31:0] clock_ms = 32'd5000;
    logic [10:0] minute_now = 11'd720;
    int          n_ticks = 0, n_taps = 0, n_touches = 0, n_unused = 0, n_settings = 0;

    always #1 i_clk = ~i_clk;

    scheduled_backlight_fader uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_kind            (in_kind),
        .i_now_ms          (in_now_ms),
        .i_clock_valid     (in_clock_valid),
        .i_minute_of_day   (in_minute),
        .i_touch_y         (in_touch_y),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_duty            (out_duty),
        .o_duty_written    (out_written),
        .o_daytime         (out_daytime),
        .o_manual_on       (out_manual_on),
        .o_peek_on         (out_peek_on),
        .o_refresh_request (out_refresh),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    scheduled_backlight_fader_chk chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_kind            (in_kind),
        .i_now_ms          (in_now_ms),
        .i_clock_valid     (in_clock_valid),
        .i_minute_of_day   (in_minute),
        .i_touch_y         (in_touch_y),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_duty            (out_duty),
        .i_duty_written    (out_written),
        .i_daytime         (out_daytime),
        .i_manual_on       (out_manual_on),
        .i_peek_on         (out_peek_on),
        .i_refresh_request (out_refresh),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding),
        .o_results         (results)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // one transaction on the item channel; payload holds until taken,
    // then the sender may go quiet for a while
    task automatic send_item(input logic [1:0] kind, input logic [31:0] now,
                             input logic cv, input logic [10:0] minute,
                             input logic [9:0] y);
        in_valid       <= 1'b1;
        in_kind        <= kind;
        in_now_ms      <= now;
        in_clock_valid <= cv;
        in_minute      <= minute;
        in_touch_y     <= y;
        do @(posedge i_clk); while (in_stall);
        case (kind)
            KIND_TICK:   n_ticks++;
            KIND_TAP:    n_taps++;
            KIND_MANUAL: n_touches++;
            default:     n_unused++;
        endcase
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // tick after dt ms; the touch field is unused here, so it gets noise
    task automatic tick_after(input logic [31:0] dt, input logic cv,
                              input logic [10:0] minute);
        clock_ms = clock_ms + dt;
        send_item(KIND_TICK, clock_ms, cv, minute, 10'($urandom_range(1023)));
    endtask

    task automatic tap_now(input logic cv, input logic [10:0] minute);
        send_item(KIND_TAP, clock_ms, cv, minute, 10'($urandom_range(1023)));
    endtask

    task automatic touch_at(input logic [9:0] y);
        send_item(KIND_MANUAL, $urandom(), 1'($urandom_range(1)),
                  11'($urandom_range(2047)), y);
    endtask

    // hold the sender until every predicted status has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // all seven registers back to back, valid stays high between writes
    task automatic apply_config(input logic [31:0] start_min, input logic [31:0] end_min,
                                input logic [31:0] day, input logic [31:0] night,
                                input logic [31:0] peek, input logic [31:0] fade,
                                input logic [31:0] peek_len);
        logic [31:0] vals [7];
        t_cfg_idx    regs [7];
        int          k;
        vals = '{start_min, end_min, day, night, peek, fade, peek_len};
        regs = '{CFG_DAY_START, CFG_DAY_END, CFG_DAY_LEVEL, CFG_NIGHT_LEVEL,
                 CFG_PEEK_LEVEL, CFG_FADE_TIME, CFG_PEEK_TIME};
        for (k = 0; k < 7; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do @(posedge i_clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // mostly a walking day with small time steps, some jumps and noise
    task automatic random_item();
        int          pick, step_sel, walk_sel;
        logic        cv;
        logic [31:0] dt;
        pick     = $urandom_range(99);
        step_sel = $urandom_range(99);
        walk_sel = $urandom_range(99);
        cv       = ($urandom_range(99) < 85);
        if (walk_sel < 90)
            minute_now = (minute_now + 11'($urandom_range(30))) % 11'd1440;
        else if (walk_sel < 95)
            minute_now = 11'($urandom_range(1439));
        else
            minute_now = 11'($urandom_range(2047));
        if (step_sel < 5)
            dt = 32'd0;
        else if (step_sel < 85)
            dt = $urandom_range(120, 1);
        else if (step_sel < 95)
            dt = $urandom_range(5000, 121);
        else if (step_sel < 99)
            dt = $urandom_range(50000, 5001);
        else
            dt = $urandom();
        if (pick < 60) begin
            tick_after(dt, cv, minute_now);
        end else if (pick < 78) begin
            clock_ms = clock_ms + dt;
            tap_now(cv, minute_now);
        end else if (pick < 88) begin
            touch_at(10'($urandom_range(1023)));
        end else begin
            send_item(KIND_UNUSED, $urandom(), 1'($urandom_range(1)),
                      11'($urandom_range(2047)), 10'($urandom_range(1023)));
        end
    endtask

    initial begin : stimulus
        int p, n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset defaults first ----
        tick_after(32'd0, 1'b0, 11'd0);         // loads the fade clock, no movement
        tick_after(32'd16, 1'b1, 11'd720);      // first real fade toward the day level
        tick_after(32'd0, 1'b1, 11'd720);       // same time again, nothing moves
        tap_now(1'b1, 11'd420);                 // first day minute, refresh ask
        touch_at(10'd0);                        // above the strip, clamps to full
        touch_at(10'd1023);                     // below the strip, clamps to dark
        touch_at(10'd440);
        touch_at(10'd40);
        touch_at(10'd239);
        tick_after(32'd20, 1'b1, 11'd1320);     // end minute is already night
        tick_after(32'd65535, 1'b0, 11'd0);     // long gap, fade snaps to goal
        tap_now(1'b0, 11'd0);                   // dark night, peek starts
        tap_now(1'b0, 11'd0);                   // second tap cancels the peek
        tap_now(1'b0, 11'd0);                   // and peek again
        tick_after(32'd30000, 1'b1, 11'd1439);  // exactly at peek end, expires
        tap_now(1'b1, 11'd419);                 // last night minute, peek
        tick_after(32'd10, 1'b1, 11'd1319);     // day comes back, peek dropped
        send_item(KIND_UNUSED, $urandom(), 1'b1, 11'd2047, 10'd1023);
        clock_ms = 32'hFFFF_FFF0;
        tick_after(32'd0, 1'b0, 11'd0);         // jump near the top of the time range
        tick_after(32'd32, 1'b0, 11'd0);        // time wraps through zero
        tick_after(32'd5, 1'b1, 11'd2047);      // minute beyond the day, reads as night
        wait_results_drained();

        // zero fade time and a peek so long its end wraps behind now
        apply_config(32'd0, 32'd1439, 32'd255, 32'd0, 32'd255, 32'd0, 32'hFFFF_FFFF);
        tap_now(1'b0, 11'd0);
        tick_after(32'd1, 1'b0, 11'd0);
        tick_after(32'd1, 1'b1, 11'd0);

        // ---- random phases, each with its own setting and pressure ----
        for (p = 0; p < 4; p++) begin
            wait_results_drained();
            case (p)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    apply_config(32'd420, 32'd1320, 32'd200, 32'd0, 32'd128,
                                 32'd1600, 32'd30000);
                end
                1: begin
                    send_idle_pct = 58;
                    stall_pct     = 0;
                    apply_config(32'd0, 32'd1439, 32'd255, 32'd255, 32'd255,
                                 32'd1, 32'hFFFF_FFFF);
                end
                2: begin
                    // start after end, the schedule never sees day
                    send_idle_pct = 0;
                    stall_pct     = 58;
                    apply_config(32'd1439, 32'd0, 32'd0, 32'd0, 32'd0,
                                 32'd65535, 32'd0);
                end
                default: begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                    apply_config($urandom_range(1439), $urandom_range(1439),
                                 $urandom_range(255), $urandom_range(255),
                                 $urandom_range(255), $urandom_range(65535),
                                 $urandom_range(60000));
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_item();
                if ($urandom_range(59) == 0)
                    wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("covered %0d ticks, %0d taps, %0d touches, %0d unused kinds under %0d settings",
                 n_ticks, n_taps, n_touches, n_unused, n_settings);
        $display("%0d status transactions compared, %0d mismatches", results, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #1500000;
        $display("timeout with %0d status transactions still expected", outstanding);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
